### design/hysteresis_thermostat_with_warmup_assert.svh
// ----------------------------------------------------------------------------
// Thermostat assertion macros
// Shared concurrent assertion forms for the thermostat checker.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_THERMOSTAT_WITH_WARMUP_ASSERT_SVH
`define HYSTERESIS_THERMOSTAT_WITH_WARMUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THRM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("thermostat check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define THRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("thermostat check failed in the following cycle");

`endif

### design/thrm_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat package
// Widths, mode codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package thrm_pkg;

    // Field widths.
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned TEMP_W      = 12;
    localparam int unsigned TARGET_W    = 11;
    localparam int unsigned GRACE_W     = 10;
    localparam int unsigned STEP_W      = 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 10;
    // Wide enough for the signed band limits (-1023 .. 3023).
    localparam int unsigned CMP_W       = 14;

    typedef logic [MODE_W-1:0] mode_t;

    // Event codes.
    localparam mode_t MODE_SAMPLE = 3'd0;
    localparam mode_t MODE_UP     = 3'd1;
    localparam mode_t MODE_DOWN   = 3'd2;
    localparam mode_t MODE_TOGGLE = 3'd3;
    localparam mode_t MODE_STOP   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GRACE_BAND    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_STEP = 1'b1;

    // Reset values and limits, 1/16 degree units.
    localparam logic [TARGET_W-1:0] TARGET_RESET = 11'd672;
    localparam logic [TARGET_W-1:0] TARGET_MAX   = 11'd2000;
    localparam logic [GRACE_W-1:0]  GRACE_RESET  = 10'd48;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd4;

    // One input word.
    typedef struct packed {
        mode_t                    mode;
        logic signed [TEMP_W-1:0] sample;
    } thrm_item_t;

    // Configuration seen by the control logic.
    typedef struct packed {
        logic [GRACE_W-1:0] grace_band;
        logic [STEP_W-1:0]  setpoint_step;
    } thrm_cfg_t;

endpackage

### design/thrm_cfg.sv
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// Holds the hysteresis half-band and the setpoint step size.
// ----------------------------------------------------------------------------
module thrm_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [thrm_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [thrm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output thrm_pkg::thrm_cfg_t              cfg
);
    import thrm_pkg::*;

    logic [GRACE_W-1:0] grace_reg;
    logic [STEP_W-1:0]  step_reg;

    // Register writes by index; each register keeps its low bits of the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grace_reg <= GRACE_RESET;
            step_reg  <= STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_GRACE_BAND:    grace_reg <= cfg_wr_data[GRACE_W-1:0];
                CFG_SETPOINT_STEP: step_reg  <= cfg_wr_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.grace_band    = grace_reg;
    assign cfg.setpoint_step = step_reg;

endmodule

### design/thrm_in_stage.sv
// ----------------------------------------------------------------------------
// Thermostat input register
// Captures one input word and hands it to the control stage.
// ----------------------------------------------------------------------------
module thrm_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  thrm_pkg::mode_t      s_mode,
    input  logic signed [thrm_pkg::TEMP_W-1:0] s_sample,
    input  logic                 take,
    output logic                 item_valid,
    output thrm_pkg::thrm_item_t item
);
    import thrm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    thrm_item_t item_reg;

    // The register frees up whenever the control stage takes its word.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode   <= s_mode;
            item_reg.sample <= s_sample;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### design/thrm_core.sv
// ----------------------------------------------------------------------------
// Thermostat control stage
// Applies one event to the thermostat state; the state registers are the
// result word.
// ----------------------------------------------------------------------------
module thrm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  thrm_pkg::thrm_cfg_t  cfg,
    input  logic                 item_valid,
    input  thrm_pkg::thrm_item_t item,
    output logic                 take,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_heater_on,
    output logic                 m_pump_on,
    output logic                 m_regulating_active,
    output logic                 m_in_warmup,
    output logic [thrm_pkg::TARGET_W-1:0] m_target_temp
);
    import thrm_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [TARGET_W-1:0]  target_reg;
    logic [TARGET_W-1:0]  target_next;
    logic                 heater_reg;
    logic                 heater_next;
    logic                 pump_reg;
    logic                 pump_next;
    logic                 running_reg;
    logic                 running_next;
    logic                 warmup_reg;
    logic                 warmup_next;

    logic [TARGET_W:0]    up_sum;
    logic [TARGET_W-1:0]  up_val;
    logic [TARGET_W-1:0]  step_ext;
    logic [TARGET_W-1:0]  down_val;
    logic signed [CMP_W-1:0] temp_ext;
    logic signed [CMP_W-1:0] tgt_ext;
    logic signed [CMP_W-1:0] grace_ext;
    logic signed [CMP_W-1:0] band_hi;
    logic signed [CMP_W-1:0] band_lo;

    // A word moves in when the result slot is empty or being emptied.
    assign take = item_valid && (!out_valid_reg || m_ready);
    assign out_valid_next = take || (out_valid_reg && !m_ready);

    // Setpoint step up saturates at the maximum, step down at zero.
    assign step_ext = {{(TARGET_W-STEP_W){1'b0}}, cfg.setpoint_step};
    assign up_sum   = {1'b0, target_reg} + {1'b0, step_ext};
    assign up_val   = (up_sum > {1'b0, TARGET_MAX}) ? TARGET_MAX : up_sum[TARGET_W-1:0];
    assign down_val = (target_reg > step_ext) ? (target_reg - step_ext) : '0;

    // Signed band limits around the setpoint.
    assign temp_ext  = {{(CMP_W-TEMP_W){item.sample[TEMP_W-1]}}, item.sample};
    assign tgt_ext   = $signed({{(CMP_W-TARGET_W){1'b0}}, target_reg});
    assign grace_ext = $signed({{(CMP_W-GRACE_W){1'b0}}, cfg.grace_band});
    assign band_hi   = tgt_ext + grace_ext;
    assign band_lo   = tgt_ext - grace_ext;

    // Next state for the event in the input register.
    always_comb begin
        target_next  = target_reg;
        heater_next  = heater_reg;
        pump_next    = pump_reg;
        running_next = running_reg;
        warmup_next  = warmup_reg;
        case (item.mode)
            MODE_SAMPLE: begin
                if (running_reg) begin
                    if (warmup_reg) begin
                        if (temp_ext >= tgt_ext) begin
                            pump_next   = 1'b1;
                            warmup_next = 1'b0;
                        end
                    end else if (temp_ext > band_hi) begin
                        heater_next = 1'b0;
                    end else if (temp_ext < band_lo) begin
                        heater_next = 1'b1;
                    end
                end
            end
            MODE_UP: begin
                target_next = up_val;
            end
            MODE_DOWN: begin
                target_next = down_val;
            end
            MODE_TOGGLE: begin
                if (running_reg) begin
                    heater_next  = 1'b0;
                    pump_next    = 1'b0;
                    running_next = 1'b0;
                    warmup_next  = 1'b0;
                end else begin
                    heater_next  = 1'b1;
                    running_next = 1'b1;
                    warmup_next  = 1'b1;
                end
            end
            MODE_STOP: begin
                heater_next  = 1'b0;
                pump_next    = 1'b0;
                running_next = 1'b0;
                warmup_next  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // State updates only when a word moves in, so it stays put while stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            target_reg    <= TARGET_RESET;
            heater_reg    <= 1'b0;
            pump_reg      <= 1'b0;
            running_reg   <= 1'b0;
            warmup_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                target_reg  <= target_next;
                heater_reg  <= heater_next;
                pump_reg    <= pump_next;
                running_reg <= running_next;
                warmup_reg  <= warmup_next;
            end
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_heater_on         = heater_reg;
    assign m_pump_on           = pump_reg;
    assign m_regulating_active = running_reg;
    assign m_in_warmup         = warmup_reg;
    assign m_target_temp       = target_reg;

endmodule

### design/hysteresis_thermostat_with_warmup.sv
// An accepted word waits in the input register until the control stage takes
// it; its result is then held in the state/result register until taken.
// Throughput: one word per cycle; the input register and the state/result
// register form a two-stage pipe that advances whenever the result is taken.
// Reset (aresetn low at a rising edge) empties both stages, sets the setpoint
// to 42.0 degrees, turns heater and pump off and loads the register defaults.
// ----------------------------------------------------------------------------
// Hysteresis thermostat with warm-up
// Heater and pump control with a warm-up phase and a hysteresis band.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_with_warmup (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [thrm_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [thrm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [thrm_pkg::MODE_W-1:0]      s_mode,
    input  logic signed [thrm_pkg::TEMP_W-1:0] s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_heater_on,
    output logic                             m_pump_on,
    output logic                             m_regulating_active,
    output logic                             m_in_warmup,
    output logic [thrm_pkg::TARGET_W-1:0]    m_target_temp
);
    import thrm_pkg::*;

    thrm_cfg_t  cfg;
    thrm_item_t item;
    logic       item_valid;
    logic       take;

    // Configuration registers.
    thrm_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Input register.
    thrm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_sample   (s_sample),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // State update and result register.
    thrm_core u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg),
        .item_valid          (item_valid),
        .item                (item),
        .take                (take),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_heater_on         (m_heater_on),
        .m_pump_on           (m_pump_on),
        .m_regulating_active (m_regulating_active),
        .m_in_warmup         (m_in_warmup),
        .m_target_temp       (m_target_temp)
    );

endmodule

### design/thrm_checker.sv
// ----------------------------------------------------------------------------
// Thermostat port checker
// Watches the result channel for held words and consistent relay states.
// ----------------------------------------------------------------------------
`include "hysteresis_thermostat_with_warmup_assert.svh"

module thrm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_heater_on,
    input logic                          m_pump_on,
    input logic                          m_regulating_active,
    input logic                          m_in_warmup,
    input logic [thrm_pkg::TARGET_W-1:0] m_target_temp
);
    import thrm_pkg::*;

    // A stalled result word stays and does not change.
    `THRM_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_target_temp) && $stable(m_heater_on) && $stable(m_pump_on) && $stable(m_in_warmup))

    // The setpoint never leaves its saturation range.
    `THRM_ASSERT_NOW(a_target_range, aclk, aresetn, m_valid, m_target_temp <= TARGET_MAX)

    // Warm-up only while running, and the pump waits until it is over.
    `THRM_ASSERT_NOW(a_warmup_state, aclk, aresetn, m_valid && m_in_warmup, m_regulating_active && m_heater_on && !m_pump_on)

    // Stopped means both relays are off; running means at least one is on.
    `THRM_ASSERT_NOW(a_relays_follow_run, aclk, aresetn, m_valid, m_regulating_active ? (m_heater_on || m_pump_on) : (!m_heater_on && !m_pump_on))

endmodule

bind hysteresis_thermostat_with_warmup thrm_checker u_thrm_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_heater_on         (m_heater_on),
    .m_pump_on           (m_pump_on),
    .m_regulating_active (m_regulating_active),
    .m_in_warmup         (m_in_warmup),
    .m_target_temp       (m_target_temp)
);

### bench/tb_hysteresis_thermostat_with_warmup.sv
// ----------------------------------------------------------------------------
// Thermostat testbench
// Drives event words with bursty valid/ready timing and random result stalls,
// predicts every result word from an internal model of the heater and pump
// control, and checks each field of each result in order. Runs through
// several band and step settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_hysteresis_thermostat_with_warmup;
    timeunit 1ns;
    timeprecision 1ps;

    import thrm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 150;

    // Heater and pump state as seen on the result channel.
    typedef struct packed {
        logic                heater;
        logic                pump;
        logic                running;
        logic                warmup;
        logic [TARGET_W-1:0] target;
    } ctl_state_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]           cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]            cfg_wr_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [MODE_W-1:0]                s_mode = '0;
    logic signed [TEMP_W-1:0]         s_sample = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic                             m_heater_on;
    logic                             m_pump_on;
    logic                             m_regulating_active;
    logic                             m_in_warmup;
    logic [TARGET_W-1:0]              m_target_temp;

    thrm_item_t pending_words[$];
    ctl_state_t expected_states[$];

    // Live copy tracks accepted words; plan copy tracks queued words.
    ctl_state_t live_state = '{1'b0, 1'b0, 1'b0, 1'b0, TARGET_RESET};
    ctl_state_t plan_state = '{1'b0, 1'b0, 1'b0, 1'b0, TARGET_RESET};
    thrm_cfg_t  live_cfg   = '{GRACE_RESET, STEP_RESET};

    int  fail_count = 0;
    int  idle_cycles = 0;
    logic hold_wanted = 1'b0;

    hysteresis_thermostat_with_warmup u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_sample            (s_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_heater_on         (m_heater_on),
        .m_pump_on           (m_pump_on),
        .m_regulating_active (m_regulating_active),
        .m_in_warmup         (m_in_warmup),
        .m_target_temp       (m_target_temp)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Next control state after one event word.
    function automatic ctl_state_t thermostat_next(input ctl_state_t st, input thrm_cfg_t cfg,
                                                   input mode_t mode,
                                                   input logic signed [TEMP_W-1:0] temp);
        int tgt;
        int band;
        int raised;
        int lowered;
        tgt     = int'(st.target);
        band    = int'(cfg.grace_band);
        raised  = tgt + int'(cfg.setpoint_step);
        lowered = tgt - int'(cfg.setpoint_step);
        case (mode)
            MODE_SAMPLE: begin
                if (st.running) begin
                    if (st.warmup) begin
                        if (int'(temp) >= tgt) begin
                            st.pump   = 1'b1;
                            st.warmup = 1'b0;
                        end
                    end else if (int'(temp) > tgt + band) begin
                        st.heater = 1'b0;
                    end else if (int'(temp) < tgt - band) begin
                        st.heater = 1'b1;
                    end
                end
            end
            MODE_UP: begin
                st.target = (raised > int'(TARGET_MAX)) ? TARGET_MAX : raised[TARGET_W-1:0];
            end
            MODE_DOWN: begin
                st.target = (lowered > 0) ? lowered[TARGET_W-1:0] : '0;
            end
            MODE_TOGGLE, MODE_STOP: begin
                if (st.running) begin
                    st.heater  = 1'b0;
                    st.pump    = 1'b0;
                    st.running = 1'b0;
                    st.warmup  = 1'b0;
                end else if (mode == MODE_TOGGLE) begin
                    st.heater  = 1'b1;
                    st.running = 1'b1;
                    st.warmup  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return st;
    endfunction

    // A temperature close to the band edges of the planned setpoint, or anywhere.
    function automatic logic signed [TEMP_W-1:0] near_band_sample();
        int tgt;
        int band;
        int v;
        tgt  = int'(plan_state.target);
        band = int'(live_cfg.grace_band);
        case ($urandom_range(0, 5))
            0: v = tgt + band + int'($urandom_range(0, 2)) - 1;
            1: v = tgt - band + int'($urandom_range(0, 2)) - 1;
            2: v = tgt + int'($urandom_range(0, 2)) - 1;
            3: v = tgt - band - int'($urandom_range(1, 200));
            4: v = tgt + band + int'($urandom_range(1, 200));
            default: v = int'($urandom_range(0, 4095)) - 2048;
        endcase
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v[TEMP_W-1:0];
    endfunction

    task automatic queue_word(input mode_t mode, input int temp);
        thrm_item_t w;
        w.mode   = mode;
        w.sample = temp[TEMP_W-1:0];
        plan_state = thermostat_next(plan_state, live_cfg, w.mode, w.sample);
        pending_words.push_back(w);
    endtask

    // Random words, mostly well-formed control sequences steered by the plan.
    task automatic queue_random_words(input int count);
        int pick;
        int noise;
        repeat (count) begin
            pick  = $urandom_range(0, 99);
            noise = int'($urandom_range(0, 4095));
            if (pick < 8) begin
                queue_word(mode_t'($urandom_range(0, 7)), noise);
            end else if (!plan_state.running) begin
                if (pick < 60) queue_word(MODE_TOGGLE, noise);
                else if (pick < 75) queue_word(MODE_UP, noise);
                else if (pick < 90) queue_word(MODE_DOWN, noise);
                else queue_word(MODE_SAMPLE, near_band_sample());
            end else begin
                if (pick < 60) queue_word(MODE_SAMPLE, near_band_sample());
                else if (pick < 70) queue_word(MODE_UP, noise);
                else if (pick < 80) queue_word(MODE_DOWN, noise);
                else if (pick < 85) queue_word(MODE_TOGGLE, noise);
                else if (pick < 90) queue_word(MODE_STOP, noise);
                else queue_word(MODE_SAMPLE, near_band_sample());
            end
        end
    endtask

    // Wait until every queued word has been taken and every result checked.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_states.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_GRACE_BAND) live_cfg.grace_band = data[GRACE_W-1:0];
        else live_cfg.setpoint_step = data[STEP_W-1:0];
    endtask

    // Drain, let the pipe settle, then load a new band and step.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] band,
                               input logic [CFG_DATA_W-1:0] step);
        wait_drained();
        repeat (3) @(posedge aclk);
        write_reg(CFG_GRACE_BAND, band);
        write_reg(CFG_SETPOINT_STEP, step);
        @(negedge aclk);
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    // Sender: bursts of words with random gaps; predicts each accepted word.
    always @(posedge aclk) begin : send_proc
        thrm_item_t w;
        logic       offering;
        int         burst_left;
        int         gap_left;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                live_state = thermostat_next(live_state, live_cfg, s_mode, s_sample);
                expected_states.push_back(live_state);
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_mode   <= w.mode;
                    s_sample <= w.sample;
                    offering = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_valid <= offering;
        end
    end

    // Receiver: checks each result word and stalls on its own pattern.
    always @(posedge aclk) begin : recv_proc
        ctl_state_t want;
        logic       rdy;
        int         stall_timer;
        int         stall_style;
        int         hold_left;
        logic       hold_taken;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_timer = 0;
            stall_style = 0;
            hold_left   = 0;
            hold_taken  = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    $display("%0t ns: result word with none expected", $time);
                    fail_count++;
                end else begin
                    want = expected_states.pop_front();
                    check_field("heater_on", want.heater, m_heater_on);
                    check_field("pump_on", want.pump, m_pump_on);
                    check_field("regulating_active", want.running, m_regulating_active);
                    check_field("in_warmup", want.warmup, m_in_warmup);
                    check_field("target_temp", want.target, m_target_temp);
                end
            end
            // A long hold-off, once, so the pipe fills and stalls the sender.
            if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            stall_timer++;
            if (stall_timer >= 40) begin
                stall_timer = 0;
                stall_style = $urandom_range(0, 3);
            end
            case (stall_style)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = (stall_timer % 4 == 0);
                default: rdy = (stall_timer < 30);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            m_ready <= rdy;
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int tgt0;
        int band0;
        tgt0  = int'(TARGET_RESET);
        band0 = int'(GRACE_RESET);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: idle events, unused modes, warm-up, band edges, stops.
        queue_word(MODE_SAMPLE, -880);
        queue_word(MODE_SAMPLE, 2047);
        queue_word(mode_t'(5), -2048);
        queue_word(mode_t'(6), 0);
        queue_word(mode_t'(7), -1);
        queue_word(MODE_STOP, 0);
        queue_word(MODE_UP, 0);
        queue_word(MODE_DOWN, 0);
        queue_word(MODE_TOGGLE, 0);
        queue_word(MODE_SAMPLE, tgt0 - 1);
        queue_word(MODE_SAMPLE, tgt0);
        queue_word(MODE_SAMPLE, tgt0 + band0);
        queue_word(MODE_SAMPLE, tgt0 + band0 + 1);
        queue_word(MODE_SAMPLE, tgt0 - band0);
        queue_word(MODE_SAMPLE, tgt0 - band0 - 1);
        queue_word(MODE_SAMPLE, 2047);
        queue_word(MODE_SAMPLE, -2048);
        queue_word(mode_t'(7), 1365);
        queue_word(MODE_TOGGLE, -1366);
        queue_word(MODE_TOGGLE, 0);
        queue_word(MODE_SAMPLE, 2000);
        queue_word(MODE_STOP, 0);
        queue_word(MODE_STOP, 0);
        queue_word(MODE_TOGGLE, 0);

        // Reset settings, with one long receiver hold-off.
        hold_wanted = 1'b1;
        queue_random_words(90);

        // Widest band and largest step: drive the setpoint to both limits.
        reconfigure(10'd1023, 10'd255);
        repeat (6) queue_word(MODE_UP, 0);
        queue_random_words(70);
        repeat (10) queue_word(MODE_DOWN, 0);
        queue_random_words(60);

        // Narrowest band and smallest step in range.
        reconfigure(10'd2, 10'd1);
        queue_random_words(80);

        // Zero band and zero step; the step write has its upper data bits set.
        reconfigure(10'd0, 10'h300);
        queue_random_words(50);

        // A random setting inside the stated ranges.
        reconfigure(10'($urandom_range(2, 1023)), 10'($urandom_range(1, 255)));
        queue_random_words(60);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_states.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
